[rtl/core/softmax_argmax_classifier_head_assert.svh]
// Assertion macros for the classifier head top level.
`ifndef SOFTMAX_ARGMAX_CLASSIFIER_HEAD_ASSERT_SVH
`define SOFTMAX_ARGMAX_CLASSIFIER_HEAD_ASSERT_SVH

`ifndef SYNTHESIS
// A condition that must hold at every clock edge out of reset.
`define SAH_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// A condition that must hold in the same cycle as its trigger.
`define SAH_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// A condition that must hold in the cycle after its trigger.
`define SAH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SAH_ASSERT_HOLDS(lbl, cond, msg)
`define SAH_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define SAH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/sah_pkg.sv]
// Types, constants and the exponent table for the softmax/argmax classifier head.
package sah_pkg;

    // Field formats.
    localparam int FRAC_BITS   = 12;
    localparam int LOGIT_W     = 16;
    localparam int NUM_CLASSES = 5;
    localparam int CLASS_W     = 3;
    localparam int PROB_W      = 16;

    // Exponential unit.
    localparam int U_W         = LOGIT_W;
    localparam int LOG2E_W     = 17;
    localparam logic [LOG2E_W-1:0] LOG2E_Q16 = 17'd94548;
    localparam int MUL_SHIFT   = 16;
    localparam int Y_W         = U_W + LOG2E_W - MUL_SHIFT;
    localparam int K_W         = Y_W - FRAC_BITS;
    localparam int IDX_BITS    = 4;
    localparam int IPOL_BITS   = FRAC_BITS - IDX_BITS;
    localparam int EXP_W       = 17;
    localparam int DIFF_W      = 12;
    localparam int STEP_FULL_W = DIFF_W + IPOL_BITS;
    localparam int EXP_ZERO_K  = 17;
    localparam int EXP_STAGES  = 3;
    localparam logic [EXP_W-1:0] EXP_ONE = EXP_W'(1) << PROB_W;

    // Sum and divider.
    localparam int SUM_W       = 19;
    localparam int NUM_W       = 2 * PROB_W + 1;
    localparam int DEN_W       = SUM_W;
    localparam int QUO_W       = PROB_W + 1;
    localparam int DIV_STEPS   = QUO_W;
    localparam logic [NUM_W-1:0] NUM_ONE = NUM_W'(1) << (2 * PROB_W);
    localparam logic [SUM_W-1:0] SUM_MIN = SUM_W'(EXP_ONE);
    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(NUM_CLASSES) * SUM_W'(EXP_ONE);
    localparam logic [PROB_W-1:0] PROB_MAX = '1;
    localparam logic [QUO_W-1:0]  HALF_CONF = QUO_W'(1) << (PROB_W - 1);

    // Pipeline layout: three front stages, the exponential units, two sum
    // stages, the divider and the output register.
    localparam int SUM_STAGE  = 3 + EXP_STAGES + 1;
    localparam int PIPE_DEPTH = 3 + EXP_STAGES + 2 + DIV_STEPS + 1;
    localparam int NUM_EXP    = NUM_CLASSES + 1;
    localparam int BIN_LANE   = NUM_CLASSES;

    // Per-word side information carried next to the arithmetic.
    typedef struct packed {
        logic [CLASS_W-1:0] best_class;
        logic               negative;
        logic               detected;
    } side_t;

    // round(65536 * 2^(-i/16)) for i from 0 to 16.
    function automatic logic [EXP_W-1:0] pow2_neg(input logic [IDX_BITS:0] idx);
        logic [EXP_W-1:0] val;
        case (idx)
            5'd0:    val = 17'd65536;
            5'd1:    val = 17'd62757;
            5'd2:    val = 17'd60097;
            5'd3:    val = 17'd57549;
            5'd4:    val = 17'd55109;
            5'd5:    val = 17'd52773;
            5'd6:    val = 17'd50535;
            5'd7:    val = 17'd48393;
            5'd8:    val = 17'd46341;
            5'd9:    val = 17'd44376;
            5'd10:   val = 17'd42495;
            5'd11:   val = 17'd40693;
            5'd12:   val = 17'd38968;
            5'd13:   val = 17'd37316;
            5'd14:   val = 17'd35734;
            5'd15:   val = 17'd34219;
            5'd16:   val = 17'd32768;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

[rtl/core/sah_exp.sv]
// Three-stage pipelined table exponential, 65536 * exp(-u) in fixed point.
module sah_exp (
    input  logic                       clk,
    input  logic                       en,
    input  logic [sah_pkg::U_W-1:0]    u,
    output logic [sah_pkg::EXP_W-1:0]  e
);
    import sah_pkg::*;

    localparam int MUL_W = U_W + LOG2E_W;

    logic [MUL_W-1:0]       ymul;
    logic [Y_W-1:0]         y_reg;
    logic [K_W-1:0]         k;
    logic [IDX_BITS-1:0]    idx;
    logic [IPOL_BITS-1:0]   frac_low;
    logic [EXP_W-1:0]       hi;
    logic [EXP_W-1:0]       lo;
    logic [DIFF_W-1:0]      diff;
    logic [STEP_FULL_W-1:0] step_full;
    logic [EXP_W-1:0]       hi_reg;
    logic [DIFF_W-1:0]      step_reg;
    logic [K_W-1:0]         k_reg;
    logic                   zero_reg;
    logic [EXP_W-1:0]       interp;
    logic [EXP_W-1:0]       e_next;
    logic [EXP_W-1:0]       e_reg;

    // Stage one: scale by log2(e).
    assign ymul = MUL_W'(u) * MUL_W'(LOG2E_Q16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= ymul[MUL_W-1:MUL_SHIFT];
        end
    end

    // Stage two: table lookup and the interpolation step.
    assign k         = y_reg[Y_W-1:FRAC_BITS];
    assign idx       = y_reg[FRAC_BITS-1 -: IDX_BITS];
    assign frac_low  = y_reg[IPOL_BITS-1:0];
    assign hi        = pow2_neg({1'b0, idx});
    assign lo        = pow2_neg({1'b0, idx} + (IDX_BITS + 1)'(1));
    assign diff      = DIFF_W'(hi - lo);
    assign step_full = STEP_FULL_W'(diff) * STEP_FULL_W'(frac_low);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg   <= hi;
            step_reg <= step_full[STEP_FULL_W-1:IPOL_BITS];
            k_reg    <= k;
            zero_reg <= (32'(k) >= EXP_ZERO_K);
        end
    end

    // Stage three: apply the step and the integer part as a right shift.
    assign interp = hi_reg - EXP_W'(step_reg);
    assign e_next = zero_reg ? '0 : (interp >> k_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg <= e_next;
        end
    end

    assign e = e_reg;

endmodule

[rtl/core/sah_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module sah_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic [sah_pkg::NUM_W-1:0]  num,
    input  logic [sah_pkg::DEN_W-1:0]  den,
    output logic [sah_pkg::QUO_W-1:0]  quo
);
    import sah_pkg::*;

    // The top numerator bits are known to be below the divisor, so the
    // partial remainder starts with them and only QUO_W steps remain.
    logic [DEN_W-1:0] rem_reg [DIV_STEPS];
    logic [QUO_W-1:0] low_reg [DIV_STEPS];
    logic [QUO_W-1:0] quo_reg [DIV_STEPS];
    logic [DEN_W-1:0] den_reg [DIV_STEPS];

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [QUO_W-1:0] low_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic             take;

        if (i == 0)
        begin : g_first
            assign rem_in = DEN_W'(num[NUM_W-1:QUO_W]);
            assign low_in = num[QUO_W-1:0];
            assign quo_in = '0;
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign low_in = low_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        // Bring down one numerator bit and subtract when it fits.
        assign trial = {rem_in, low_in[QUO_W-1]};
        assign take  = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
                low_reg[i] <= {low_in[QUO_W-2:0], 1'b0};
                quo_reg[i] <= {quo_in[QUO_W-2:0], take};
                den_reg[i] <= den_in;
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

[rtl/core/softmax_argmax_classifier_head.sv]
// Top level of the five-class softmax/argmax head with a sigmoid detector.
//
//   channel   valid          stall          payload
//   -------   ------------   ------------   ---------------------------------------------
//   logits    logit_valid    logit_stall    logit_zero .. logit_four, binary_logit
//   results   result_valid   result_stall   best_class, best_probability,
//                                           binary_detected, binary_confidence
//
// One word is accepted per cycle unless a held-up result freezes the pipeline. Most of
// the pipeline lies in the two 17-stage dividers (one quotient bit per stage) behind
// the three-stage table exponentials.
// Reset clears only the valid bits of the pipeline; no state survives a word.
// A stalled result freezes the whole pipeline, so logit_stall follows
// result_stall while a result is waiting; bubbles move with the data.
module softmax_argmax_classifier_head (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                logit_valid,
    output logic                                logit_stall,
    input  logic signed [sah_pkg::LOGIT_W-1:0]  logit_zero,
    input  logic signed [sah_pkg::LOGIT_W-1:0]  logit_one,
    input  logic signed [sah_pkg::LOGIT_W-1:0]  logit_two,
    input  logic signed [sah_pkg::LOGIT_W-1:0]  logit_three,
    input  logic signed [sah_pkg::LOGIT_W-1:0]  logit_four,
    input  logic signed [sah_pkg::LOGIT_W-1:0]  binary_logit,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [sah_pkg::CLASS_W-1:0]         best_class,
    output logic [sah_pkg::PROB_W-1:0]          best_probability,
    output logic                                binary_detected,
    output logic [sah_pkg::PROB_W-1:0]          binary_confidence
);
    import sah_pkg::*;

`include "softmax_argmax_classifier_head_assert.svh"

    // Saturate a quotient to the probability range.
    function automatic logic [PROB_W-1:0] sat_prob(input logic [QUO_W-1:0] q);
        return q[QUO_W-1] ? PROB_MAX : q[PROB_W-1:0];
    endfunction

    logic                      en;
    logic [PIPE_DEPTH-1:0]     valid_reg;

    logic signed [LOGIT_W-1:0] lg_in [NUM_CLASSES];
    logic                      pick01;
    logic                      pick23;

    logic signed [LOGIT_W-1:0] lg_s1_reg [NUM_CLASSES];
    logic signed [LOGIT_W-1:0] bin_s1_reg;
    logic signed [LOGIT_W-1:0] m01_reg;
    logic signed [LOGIT_W-1:0] m23_reg;
    logic [CLASS_W-1:0]        b01_reg;
    logic [CLASS_W-1:0]        b23_reg;

    logic                      pick_hi;
    logic signed [LOGIT_W-1:0] m0123;
    logic [CLASS_W-1:0]        b0123;
    logic                      pick4;

    logic signed [LOGIT_W-1:0] lg_s2_reg [NUM_CLASSES];
    logic signed [LOGIT_W-1:0] bin_s2_reg;
    logic signed [LOGIT_W-1:0] mx_s2_reg;
    logic [CLASS_W-1:0]        best_s2_reg;

    logic                      bin_neg;
    logic [U_W-1:0]            u_s3_reg [NUM_EXP];
    side_t                     side_s3_reg;

    logic [EXP_W-1:0]          e_out [NUM_EXP];
    side_t                     side_exp_reg [EXP_STAGES];

    logic [SUM_W-1:0]          s01_reg;
    logic [SUM_W-1:0]          s23_reg;
    logic [EXP_W-1:0]          e4_reg;
    logic [DEN_W-1:0]          bden_s7_reg;
    logic [NUM_W-1:0]          bnum_s7_reg;
    side_t                     side_s7_reg;

    logic [SUM_W-1:0]          sum_s8_reg;
    logic [DEN_W-1:0]          bden_s8_reg;
    logic [NUM_W-1:0]          bnum_s8_reg;
    side_t                     side_s8_reg;

    logic [QUO_W-1:0]          prob_quo;
    logic [QUO_W-1:0]          conf_quo;
    side_t                     side_div_reg [DIV_STEPS];

    logic [CLASS_W-1:0]        best_class_reg;
    logic [PROB_W-1:0]         best_probability_reg;
    logic                      binary_detected_reg;
    logic [PROB_W-1:0]         binary_confidence_reg;

    // The pipeline moves as one unless a finished result is held up.
    assign en          = !(valid_reg[PIPE_DEPTH-1] && result_stall);
    assign logit_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], logit_valid};
        end
    end

    // Stage one: pairwise compares; a later index wins only when strictly larger.
    assign lg_in[0] = logit_zero;
    assign lg_in[1] = logit_one;
    assign lg_in[2] = logit_two;
    assign lg_in[3] = logit_three;
    assign lg_in[4] = logit_four;
    assign pick01   = (lg_in[1] > lg_in[0]);
    assign pick23   = (lg_in[3] > lg_in[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                lg_s1_reg[i] <= lg_in[i];
            end
            bin_s1_reg <= binary_logit;
            m01_reg    <= pick01 ? lg_in[1] : lg_in[0];
            b01_reg    <= pick01 ? CLASS_W'(1) : CLASS_W'(0);
            m23_reg    <= pick23 ? lg_in[3] : lg_in[2];
            b23_reg    <= pick23 ? CLASS_W'(3) : CLASS_W'(2);
        end
    end

    // Stage two: finish the maximum search with the last class.
    assign pick_hi = (m23_reg > m01_reg);
    assign m0123   = pick_hi ? m23_reg : m01_reg;
    assign b0123   = pick_hi ? b23_reg : b01_reg;
    assign pick4   = (lg_s1_reg[4] > m0123);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lg_s2_reg   <= lg_s1_reg;
            bin_s2_reg  <= bin_s1_reg;
            mx_s2_reg   <= pick4 ? lg_s1_reg[4] : m0123;
            best_s2_reg <= pick4 ? CLASS_W'(4) : b0123;
        end
    end

    // Stage three: distances below the maximum and the detector magnitude.
    assign bin_neg = bin_s2_reg[LOGIT_W-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                u_s3_reg[i] <= U_W'(mx_s2_reg - lg_s2_reg[i]);
            end
            u_s3_reg[BIN_LANE]     <= bin_neg ? U_W'(-bin_s2_reg) : U_W'(bin_s2_reg);
            side_s3_reg.best_class <= best_s2_reg;
            side_s3_reg.negative   <= bin_neg;
            side_s3_reg.detected   <= !bin_neg && (bin_s2_reg != '0);
        end
    end

    // Six exponential lanes: five classes and the detector.
    for (genvar g = 0; g < NUM_EXP; g++)
    begin : g_exp
        sah_exp u_exp (
            .clk (clk),
            .en  (en),
            .u   (u_s3_reg[g]),
            .e   (e_out[g])
        );
    end

    // Side information rides along the exponential stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_exp_reg[0] <= side_s3_reg;
            for (int i = 1; i < EXP_STAGES; i++)
            begin
                side_exp_reg[i] <= side_exp_reg[i-1];
            end
        end
    end

    // Stages seven and eight: sum tree and the sigmoid fraction.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s01_reg     <= SUM_W'(e_out[0]) + SUM_W'(e_out[1]);
            s23_reg     <= SUM_W'(e_out[2]) + SUM_W'(e_out[3]);
            e4_reg      <= e_out[4];
            bden_s7_reg <= DEN_W'(EXP_ONE) + DEN_W'(e_out[BIN_LANE]);
            bnum_s7_reg <= side_exp_reg[EXP_STAGES-1].negative
                           ? (NUM_W'(e_out[BIN_LANE]) << PROB_W) : NUM_ONE;
            side_s7_reg <= side_exp_reg[EXP_STAGES-1];

            sum_s8_reg  <= s01_reg + s23_reg + SUM_W'(e4_reg);
            bden_s8_reg <= bden_s7_reg;
            bnum_s8_reg <= bnum_s7_reg;
            side_s8_reg <= side_s7_reg;
        end
    end

    // Probability and sigmoid dividers run side by side.
    sah_div u_prob_div (
        .clk (clk),
        .en  (en),
        .num (NUM_ONE),
        .den (DEN_W'(sum_s8_reg)),
        .quo (prob_quo)
    );

    sah_div u_conf_div (
        .clk (clk),
        .en  (en),
        .num (bnum_s8_reg),
        .den (bden_s8_reg),
        .quo (conf_quo)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_div_reg[0] <= side_s8_reg;
            for (int i = 1; i < DIV_STEPS; i++)
            begin
                side_div_reg[i] <= side_div_reg[i-1];
            end
        end
    end

    // Output register with saturation.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            best_class_reg        <= side_div_reg[DIV_STEPS-1].best_class;
            best_probability_reg  <= sat_prob(prob_quo);
            binary_detected_reg   <= side_div_reg[DIV_STEPS-1].detected;
            binary_confidence_reg <= sat_prob(conf_quo);
        end
    end

    assign result_valid      = valid_reg[PIPE_DEPTH-1];
    assign best_class        = best_class_reg;
    assign best_probability  = best_probability_reg;
    assign binary_detected   = binary_detected_reg;
    assign binary_confidence = binary_confidence_reg;

    // A frozen pipeline keeps every valid bit in place.
    `SAH_ASSERT_NEXT(a_freeze_holds, !en, $stable(valid_reg), "valid bits moved during a stall")
    // The exponential sum always contains the winner's full weight.
    `SAH_ASSERT_IMPLIES(a_sum_range, valid_reg[SUM_STAGE], (sum_s8_reg >= SUM_MIN) && (sum_s8_reg <= SUM_MAX), "class exponential sum out of range")
    // The winning class index stays among the classes.
    `SAH_ASSERT_IMPLIES(a_class_range, result_valid, best_class < CLASS_W'(NUM_CLASSES), "best class index out of range")
    // A positive detector logit and a confidence above one half go together.
    `SAH_ASSERT_IMPLIES(a_detect_conf, result_valid, binary_detected == (QUO_W'(binary_confidence) > HALF_CONF), "detector flag disagrees with confidence")

endmodule

[bench/softmax_score_checker.sv]
`timescale 1ns / 1ps
// Checker for the classifier head: predicts each result word and compares it with the output.
module softmax_score_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                logit_valid,
    input  logic                                logit_stall,
    input  logic signed [sah_pkg::LOGIT_W-1:0]  logit_zero,
    input  logic signed [sah_pkg::LOGIT_W-1:0]  logit_one,
    input  logic signed [sah_pkg::LOGIT_W-1:0]  logit_two,
    input  logic signed [sah_pkg::LOGIT_W-1:0]  logit_three,
    input  logic signed [sah_pkg::LOGIT_W-1:0]  logit_four,
    input  logic signed [sah_pkg::LOGIT_W-1:0]  binary_logit,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  logic [sah_pkg::CLASS_W-1:0]         best_class,
    input  logic [sah_pkg::PROB_W-1:0]          best_probability,
    input  logic                                binary_detected,
    input  logic [sah_pkg::PROB_W-1:0]          binary_confidence,
    output int                                  mismatch_count,
    output int                                  scores_pending
);

    localparam int FRAC       = sah_pkg::FRAC_BITS;
    localparam int SEG_SHIFT  = FRAC - 4;
    localparam int STEP_W     = 17;
    localparam longint LOG2E  = 94548;

    // 2^(-i/16) in Q16 for i = 0..16; entry i sits at bit i*17.
    localparam logic [17*STEP_W-1:0] POW2_STEPS = {
        17'd32768, 17'd34219, 17'd35734, 17'd37316, 17'd38968, 17'd40693,
        17'd42495, 17'd44376, 17'd46341, 17'd48393, 17'd50535, 17'd52773,
        17'd55109, 17'd57549, 17'd60097, 17'd62757, 17'd65536
    };

    typedef struct packed {
        logic [sah_pkg::CLASS_W-1:0] best_class;
        logic [sah_pkg::PROB_W-1:0]  best_probability;
        logic                        binary_detected;
        logic [sah_pkg::PROB_W-1:0]  binary_confidence;
    } score_t;

    score_t pending_scores[$];
    int     errors = 0;

    assign mismatch_count = errors;

    // Table exponential: about 65536 * exp(-u / 2^FRAC), zero once the octave reaches 17.
    function automatic longint neg_exp_q16(input logic [15:0] u);
        longint y;
        int     octave;
        int     frac;
        int     seg;
        int     ipol_pos;
        int     hi;
        int     lo;
        int     v;
        y        = (longint'(u) * LOG2E) >> 16;
        octave   = int'(y >> FRAC);
        frac     = int'(y) & ((1 << FRAC) - 1);
        seg      = frac >> SEG_SHIFT;
        ipol_pos = frac & ((1 << SEG_SHIFT) - 1);
        hi       = int'(POW2_STEPS[seg*STEP_W +: STEP_W]);
        lo       = int'(POW2_STEPS[(seg+1)*STEP_W +: STEP_W]);
        v        = hi - (((hi - lo) * ipol_pos) >> SEG_SHIFT);
        if (octave >= 17)
        begin
            return 0;
        end
        return longint'(v >> octave);
    endfunction

    // Argmax, softmax probability of the winner and sigmoid of the detector logit.
    function automatic score_t predict_score(input logic [4:0][15:0] logits,
                                             input logic [15:0] detector);
        score_t s;
        int     lg[5];
        int     peak;
        int     winner;
        int     bx;
        longint total;
        longint quo;
        longint e;
        longint conf;
        for (int i = 0; i < 5; i++)
        begin
            lg[i] = int'($signed(logits[i]));
        end
        peak   = lg[0];
        winner = 0;
        for (int i = 1; i < 5; i++)
        begin
            if (lg[i] > peak)
            begin
                peak   = lg[i];
                winner = i;
            end
        end
        total = 0;
        for (int i = 0; i < 5; i++)
        begin
            total += neg_exp_q16(16'(peak - lg[i]));
        end
        quo = (longint'(1) << 32) / total;

        bx = int'($signed(detector));
        if (bx >= 0)
        begin
            e    = neg_exp_q16(16'(bx));
            conf = (longint'(1) << 32) / (65536 + e);
        end
        else
        begin
            e    = neg_exp_q16(16'(-bx));
            conf = (e << 16) / (65536 + e);
        end

        s.best_class        = 3'(winner);
        s.best_probability  = (quo > 65535) ? 16'hFFFF : 16'(quo);
        s.binary_detected   = (bx > 0);
        s.binary_confidence = (conf > 65535) ? 16'hFFFF : 16'(conf);
        return s;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Retire result words against the oldest prediction, then queue a prediction per logit word.
    always @(posedge clk or negedge rst_n)
    begin
        score_t want;
        if (!rst_n)
        begin
            pending_scores.delete();
            scores_pending <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_scores.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word, expected none actual class %0d prob %0d",
                             $time, best_class, best_probability);
                end
                else
                begin
                    want = pending_scores.pop_front();
                    check_field("best_class", want.best_class, best_class);
                    check_field("best_probability", want.best_probability, best_probability);
                    check_field("binary_detected", want.binary_detected, binary_detected);
                    check_field("binary_confidence", want.binary_confidence, binary_confidence);
                end
            end
            if (logit_valid && !logit_stall)
            begin
                pending_scores.push_back(predict_score(
                    {logit_four, logit_three, logit_two, logit_one, logit_zero}, binary_logit));
            end
            scores_pending <= pending_scores.size();
        end
    end

endmodule

[bench/tb_softmax_argmax_classifier_head.sv]
`timescale 1ns / 1ps
// Testbench top for the classifier head: clock, reset, stimulus, stall control and verdict.
module tb_softmax_argmax_classifier_head;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_WORDS    = 320;
    localparam int DRAIN_CYCLES   = 40;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                               clk;
    logic                               rst_n;
    logic                               logit_valid;
    logic                               logit_stall;
    logic signed [sah_pkg::LOGIT_W-1:0] logit_zero;
    logic signed [sah_pkg::LOGIT_W-1:0] logit_one;
    logic signed [sah_pkg::LOGIT_W-1:0] logit_two;
    logic signed [sah_pkg::LOGIT_W-1:0] logit_three;
    logic signed [sah_pkg::LOGIT_W-1:0] logit_four;
    logic signed [sah_pkg::LOGIT_W-1:0] binary_logit;
    logic                               result_valid;
    logic                               result_stall;
    logic [sah_pkg::CLASS_W-1:0]        best_class;
    logic [sah_pkg::PROB_W-1:0]         best_probability;
    logic                               binary_detected;
    logic [sah_pkg::PROB_W-1:0]         binary_confidence;

    int         mismatch_count;
    int         scores_pending;
    idle_mode_t idle_mode = IDLE_NONE;
    int         holds_requested = 0;

    softmax_argmax_classifier_head i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .logit_valid       (logit_valid),
        .logit_stall       (logit_stall),
        .logit_zero        (logit_zero),
        .logit_one         (logit_one),
        .logit_two         (logit_two),
        .logit_three       (logit_three),
        .logit_four        (logit_four),
        .binary_logit      (binary_logit),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .best_class        (best_class),
        .best_probability  (best_probability),
        .binary_detected   (binary_detected),
        .binary_confidence (binary_confidence)
    );

    softmax_score_checker i_score_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .logit_valid       (logit_valid),
        .logit_stall       (logit_stall),
        .logit_zero        (logit_zero),
        .logit_one         (logit_one),
        .logit_two         (logit_two),
        .logit_three       (logit_three),
        .logit_four        (logit_four),
        .binary_logit      (binary_logit),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .best_class        (best_class),
        .best_probability  (best_probability),
        .binary_detected   (binary_detected),
        .binary_confidence (binary_confidence),
        .mismatch_count    (mismatch_count),
        .scores_pending    (scores_pending)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Decide whether one side idles this cycle under the current mode.
    function automatic bit take_gap(input bit sender_side);
        int pct;
        case (idle_mode)
            IDLE_SENDER:
            begin
                pct = sender_side ? 45 : 0;
            end
            IDLE_RECEIVER:
            begin
                pct = sender_side ? 0 : 45;
            end
            IDLE_BOTH:
            begin
                pct = 19;
            end
            default:
            begin
                pct = 0;
            end
        endcase
        return $urandom_range(0, 99) < pct;
    endfunction

    // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
    initial
    begin
        int holds_served;
        int hold_left;
        holds_served = 0;
        hold_left    = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_requested)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= take_gap(1'b0);
            end
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (logit_valid && !logit_stall) || (result_valid && !result_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Offer one logit word, with optional idle cycles ahead of it, and wait until it is taken.
    task automatic offer_word(input int l0, input int l1, input int l2, input int l3,
                              input int l4, input int det);
        while (take_gap(1'b1))
        begin
            logit_valid <= 1'b0;
            @(posedge clk);
        end
        logit_valid  <= 1'b1;
        logit_zero   <= 16'(l0);
        logit_one    <= 16'(l1);
        logit_two    <= 16'(l2);
        logit_three  <= 16'(l3);
        logit_four   <= 16'(l4);
        binary_logit <= 16'(det);
        @(posedge clk);
        while (logit_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Random logit word: fully random, clustered around a base, or with a tie at the top.
    task automatic offer_random_word();
        int w[6];
        int kind;
        int base;
        int spread;
        int top;
        int slot;
        kind = $urandom_range(0, 9);
        base = int'($urandom_range(0, 65535)) - 32768;
        case ($urandom_range(0, 3))
            0:
            begin
                spread = 15;
            end
            1:
            begin
                spread = 255;
            end
            2:
            begin
                spread = 4095;
            end
            default:
            begin
                spread = 32767;
            end
        endcase
        for (int i = 0; i < 5; i++)
        begin
            if (kind <= 2)
            begin
                w[i] = int'($urandom_range(0, 65535)) - 32768;
            end
            else
            begin
                w[i] = base + int'($urandom_range(0, 2 * spread)) - spread;
                if (w[i] > 32767)
                begin
                    w[i] = 32767;
                end
                else if (w[i] < -32768)
                begin
                    w[i] = -32768;
                end
            end
        end
        // Copy the maximum into a random class, which forces a tie unless it picks the maximum itself.
        if (kind >= 7)
        begin
            top = 0;
            for (int i = 1; i < 5; i++)
            begin
                if (w[i] > w[top])
                begin
                    top = i;
                end
            end
            slot    = $urandom_range(0, 4);
            w[slot] = w[top];
        end
        if ($urandom_range(0, 2) == 0)
        begin
            w[5] = int'($urandom_range(0, 8192)) - 4096;
        end
        else
        begin
            w[5] = int'($urandom_range(0, 65535)) - 32768;
        end
        offer_word(w[0], w[1], w[2], w[3], w[4], w[5]);
    endtask

    // Stop sending and let every outstanding result word come back.
    task automatic drain_results();
        logit_valid <= 1'b0;
        @(posedge clk);
        while (scores_pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Reset, directed words, then random phases under each idling mode.
    initial
    begin
        int dets[5];
        dets = '{1, -1, 4096, -4096, 12288};
        rst_n        <= 1'b0;
        logit_valid  <= 1'b0;
        logit_zero   <= '0;
        logit_one    <= '0;
        logit_two    <= '0;
        logit_three  <= '0;
        logit_four   <= '0;
        binary_logit <= '0;
        repeat (6)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // Five-way ties, field extremes and detector logit at its limits.
        offer_word(0, 0, 0, 0, 0, 0);
        offer_word(32767, 32767, 32767, 32767, 32767, 32767);
        offer_word(-32768, -32768, -32768, -32768, -32768, -32768);
        // One dominant class in each position: probability saturates.
        for (int i = 0; i < 5; i++)
        begin
            offer_word(i == 0 ? 32767 : -32768, i == 1 ? 32767 : -32768,
                       i == 2 ? 32767 : -32768, i == 3 ? 32767 : -32768,
                       i == 4 ? 32767 : -32768, dets[i]);
        end
        // Tied maxima away from index zero, close logits and mixed spreads.
        offer_word(0, 0, 1000, 0, 1000, 2);
        offer_word(-100, -5, -100, -5, -100, -2);
        offer_word(0, 1, 2, 3, 4, 20000);
        offer_word(4, 3, 2, 1, 0, -20000);
        offer_word(32767, -32768, 0, 16384, -16384, 100);
        offer_word(-1, -1, -1, -1, 0, -100);
        offer_word(4096, 0, -4096, 8192, -8192, 8191);
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_mode = idle_mode_t'(phase);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Long hold-off on the result side while words keep coming.
                if (n == 100 && (idle_mode == IDLE_NONE || idle_mode == IDLE_RECEIVER))
                begin
                    holds_requested++;
                end
                offer_random_word();
            end
            drain_results();
        end

        idle_mode = IDLE_NONE;
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
        if (mismatch_count == 0 && scores_pending == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
